>>> hdl/gof_pkg.sv
// Shared types and constants for the glyph outline filter.
`timescale 1ns / 1ps
`default_nettype none

package gof_pkg;

  // Field widths of the channels
  localparam int GOF_PIX_W     = 8;
  localparam int GOF_ROW_W     = 10;
  localparam int GOF_COL_OUT_W = 6;
  localparam int GOF_OUT_W     = GOF_ROW_W + GOF_COL_OUT_W + GOF_PIX_W;

  // Configuration registers
  localparam int GOF_FW_W      = 7;
  localparam int GOF_FH_W      = 11;
  localparam int GOF_CFG_W     = 11;
  localparam int GOF_CFG_IDX_W = 2;
  localparam logic [GOF_CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [GOF_CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [GOF_FW_W-1:0] GOF_FW_RESET = 7'd32;
  localparam logic [GOF_FH_W-1:0] GOF_FH_RESET = 11'd32;
  localparam logic [GOF_FH_W-1:0] GOF_MAX_HEIGHT = 11'd1024;

  localparam int GOF_DEFAULT_MAX_WIDTH = 64;

  // Each memory word holds one column of the three row slots
  localparam int GOF_SLOTS  = 3;
  localparam int GOF_WORD_W = GOF_SLOTS * GOF_PIX_W;

  // Result kinds, one mask bit each, in raster order
  localparam int RES_UP_PREV = 0;   // (r-1, c-1)
  localparam int RES_UP_END  = 1;   // (r-1, W-1)
  localparam int RES_LO_PREV = 2;   // (r,   c-1), last row only
  localparam int RES_LO_END  = 3;   // (r,   W-1), last row only
  localparam int GOF_KINDS   = 4;

  // One column of the window, rows r-2, r-1, r
  typedef struct packed {
    logic [GOF_PIX_W-1:0] older;
    logic [GOF_PIX_W-1:0] prev;
    logic [GOF_PIX_W-1:0] cur;
  } gof_col_t;

  // Position data of one item, worked out when it is taken
  typedef struct packed {
    logic [GOF_KINDS-1:0]     mask;
    logic [GOF_ROW_W-1:0]     row;
    logic [GOF_COL_OUT_W-1:0] col_prev;
    logic [GOF_COL_OUT_W-1:0] col_end;
    logic                     up_clamp;    // row r-1 is the top row
    logic                     lo_clamp;    // row r is the top row
    logic                     lclamp_prev; // column c-1 is the first column
    logic                     lclamp_end;  // column c is the first column
  } gof_pos_t;

  // Work handed to the result stage: position plus three columns
  typedef struct packed {
    gof_pos_t pos;
    gof_col_t v2;   // column c-2
    gof_col_t v1;   // column c-1
    gof_col_t v0;   // column c
  } gof_job_t;

  function automatic logic [GOF_PIX_W-1:0] gof_max2(input logic [GOF_PIX_W-1:0] a,
                                                    input logic [GOF_PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/gof_column_store.sv
// Column store: three row slots per column, read-modify-write with forwarding.
`timescale 1ns / 1ps
`default_nettype none

module gof_column_store import gof_pkg::*; #(
  parameter  int MAX_WIDTH = GOF_DEFAULT_MAX_WIDTH,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [1:0]           wr_slot,
  input  wire logic [GOF_PIX_W-1:0] wr_pixel,
  output gof_col_t                  col_out
);

  logic [GOF_WORD_W-1:0] store_r [MAX_WIDTH];
  logic [GOF_WORD_W-1:0] rd_q_r;
  logic [GOF_WORD_W-1:0] fwd_word_r;
  logic                  fwd_hit_r;
  logic [GOF_WORD_W-1:0] raw_word;
  logic [GOF_WORD_W-1:0] wr_word;
  logic [1:0]            older_slot;
  logic [1:0]            prev_slot;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_q_r     <= store_r[rd_addr];
      fwd_word_r <= wr_word;
    end
  end

  // A read that meets a write to the same column takes the merged word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (rd_addr == wr_addr);
    end
  end

  // Merge the new pixel into its row slot
  always_comb begin
    raw_word = fwd_hit_r ? fwd_word_r : rd_q_r;
    wr_word  = raw_word;
    case (wr_slot)
      2'd0:    wr_word[0*GOF_PIX_W +: GOF_PIX_W] = wr_pixel;
      2'd1:    wr_word[1*GOF_PIX_W +: GOF_PIX_W] = wr_pixel;
      default: wr_word[2*GOF_PIX_W +: GOF_PIX_W] = wr_pixel;
    endcase
  end

  // Slots of rows r-2 and r-1, then reorder the column by row
  assign older_slot = (wr_slot == 2'd2) ? 2'd0 : wr_slot + 2'd1;
  assign prev_slot  = (wr_slot == 2'd0) ? 2'd2 : wr_slot - 2'd1;

  always_comb begin
    col_out.older = raw_word[older_slot*GOF_PIX_W +: GOF_PIX_W];
    col_out.prev  = raw_word[prev_slot*GOF_PIX_W +: GOF_PIX_W];
    col_out.cur   = wr_pixel;
  end

endmodule

`default_nettype wire

>>> hdl/gof_emitter.sv
// Result stage: steps through the results of one item and computes each value.
`timescale 1ns / 1ps
`default_nettype none

module gof_emitter import gof_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_load,
  input  gof_job_t                  job_in,
  output logic                      emit_ready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [GOF_OUT_W-1:0]      out_tdata,  // out_row, out_col, out_value
  output logic                      out_tlast   // run_last
);

  typedef struct packed {
    logic [GOF_PIX_W-1:0] top;
    logic [GOF_PIX_W-1:0] mid;
    logic [GOF_PIX_W-1:0] bot;
  } gof_tap_t;

  gof_job_t               job_r;
  logic                   job_v_r;
  logic                   out_v_r;
  logic [GOF_OUT_W-1:0]   out_data_r;
  logic                   out_last_r;

  logic [GOF_KINDS-1:0]   pick;
  logic [GOF_KINDS-1:0]   remaining;
  logic                   out_free;
  logic                   emitting;
  logic                   upper;
  logic                   at_end;
  gof_col_t               col_l, col_c, col_r;
  gof_tap_t               tap_l, tap_c, tap_r;
  logic [GOF_PIX_W-1:0]   n1, n2;
  logic [GOF_PIX_W+1:0]   wsum;
  logic [GOF_PIX_W-1:0]   edge_val;
  logic [GOF_PIX_W-1:0]   value;
  logic [GOF_ROW_W-1:0]   res_row;
  logic [GOF_COL_OUT_W-1:0] res_col;

  // Map a stored column onto the top, middle and bottom rows of the window
  function automatic gof_tap_t map_rows(input gof_col_t v, input logic up,
                                        input logic up_clamp, input logic lo_clamp);
    gof_tap_t t;
    if (up) begin
      t.top = up_clamp ? v.prev : v.older;
      t.mid = v.prev;
      t.bot = v.cur;
    end else begin
      t.top = lo_clamp ? v.cur : v.prev;
      t.mid = v.cur;
      t.bot = v.cur;
    end
    return t;
  endfunction

  // Lowest pending result goes first
  assign pick       = job_r.pos.mask & (~job_r.pos.mask + 4'd1);
  assign remaining  = job_r.pos.mask & ~pick;
  assign out_free   = !out_v_r || out_tready;
  assign emitting   = job_v_r && out_free;
  assign emit_ready = !job_v_r || (out_free && (remaining == '0));

  // Window for the picked result
  always_comb begin
    upper  = pick[RES_UP_PREV] | pick[RES_UP_END];
    at_end = pick[RES_UP_END] | pick[RES_LO_END];
    if (at_end) begin
      col_l = job_r.pos.lclamp_end ? job_r.v0 : job_r.v1;
      col_c = job_r.v0;
      col_r = job_r.v0;
    end else begin
      col_l = job_r.pos.lclamp_prev ? job_r.v1 : job_r.v2;
      col_c = job_r.v1;
      col_r = job_r.v0;
    end
    tap_l = map_rows(col_l, upper, job_r.pos.up_clamp, job_r.pos.lo_clamp);
    tap_c = map_rows(col_c, upper, job_r.pos.up_clamp, job_r.pos.lo_clamp);
    tap_r = map_rows(col_r, upper, job_r.pos.up_clamp, job_r.pos.lo_clamp);
  end

  // Outline or body value
  always_comb begin
    n1 = gof_max2(gof_max2(tap_l.mid, tap_r.mid), gof_max2(tap_c.top, tap_c.bot));
    n2 = gof_max2(gof_max2(tap_l.top, tap_r.top), gof_max2(tap_l.bot, tap_r.bot));
    wsum = {2'b00, n1} + {1'b0, n1, 1'b0} + {2'b00, n2};
    edge_val = wsum[GOF_PIX_W+1:2];
    if (tap_c.mid == '0) begin
      value = {1'b0, edge_val[GOF_PIX_W-1:1]};
    end else begin
      value = {1'b1, tap_c.mid[GOF_PIX_W-1:1]};
    end
    // values above 128 in the first and last column of a row are halved
    if ((at_end || job_r.pos.lclamp_prev) && (value > 8'd128)) begin
      value = {1'b0, value[GOF_PIX_W-1:1]};
    end
    res_row = upper ? job_r.pos.row - 10'd1 : job_r.pos.row;
    res_col = at_end ? job_r.pos.col_end : job_r.pos.col_prev;
  end

  // Control: job and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (job_load) begin
        job_v_r <= 1'b1;
      end else if (emitting && (remaining == '0)) begin
        job_v_r <= 1'b0;
      end
      if (emitting) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload: job descriptor and output register
  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end else if (emitting) begin
      job_r.pos.mask <= remaining;
    end
    if (emitting) begin
      out_data_r <= {value, res_col, res_row};
      out_last_r <= (remaining == '0);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A held job always has something left to send
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r |-> (job_r.pos.mask != '0))
    else $error("result job held with empty mask");

  // A result that is not the last of its item leaves the job pending
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> job_v_r)
    else $error("non-last result without pending job");

  // No new job while the current one still has results behind this one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (job_load && job_v_r) |-> (emitting && (remaining == '0)))
    else $error("job loaded over pending results");

endmodule

`default_nettype wire

>>> hdl/glyph_outline_filter_unit.sv
// Top level of the glyph outline filter: position tracking, stages and config.
//
// Streaming 3x3 outline filter for 8-bit glyph coverage bitmaps.
// in_*  : one coverage pixel per item, raster order, row after row.
// out_* : result items, tdata = {out_value, out_col, out_row}, tlast marks
//         the last result caused by one input pixel.
// cfg_* : write-only registers, index 0 frame_width, 1 frame_height; any
//         write to either restarts the frame at row 0, column 0.
// Pixel (r,c) gives result (r-1,c-1); a row end adds (r-1,W-1), and the
// last row adds its own results, up to four per pixel.
// Path: a taken pixel passes the merge stage (the column read shares the
// taking edge), then the job register and the result register. The result
// stage sends one result per cycle while the receiver takes them, so the
// column store is read once per item and a plain pixel flows at one item
// per cycle unless the output stalls; row ends and the last row cause up
// to four results, and the next item waits until they are sent.
// Reset clears the counters and the configuration (32 x 32); the column
// store is not cleared and needs no pass. A stalled receiver holds the
// output register; one item waits in the result stage and one in the
// merge stage, then in_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module glyph_outline_filter_unit import gof_pkg::*; #(
  parameter  int MAX_WIDTH = GOF_DEFAULT_MAX_WIDTH,
  localparam int AW        = $clog2(MAX_WIDTH),
  localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [GOF_PIX_W-1:0]     in_tdata,   // pixel_in
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [GOF_OUT_W-1:0]          out_tdata,  // out_row, out_col, out_value
  output logic                          out_tlast,  // run_last
  input  wire logic                     cfg_we,
  input  wire logic [GOF_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GOF_CFG_W-1:0]     cfg_wdata
);

  logic [GOF_FW_W-1:0]  frame_width_r;
  logic [GOF_FH_W-1:0]  frame_height_r;
  logic [AW-1:0]        col_r, col_nxt;
  logic [GOF_ROW_W-1:0] row_r, row_nxt;
  logic [1:0]           slot_r, slot_nxt;

  logic [WW-1:0]        eff_w;
  logic [GOF_FH_W-1:0]  eff_h;
  logic                 restart;
  logic [AW-1:0]        c0;
  logic [GOF_ROW_W-1:0] r0;
  logic [1:0]           slot0;
  logic                 row_end0;
  logic                 last_row0;
  logic                 in_accept;
  gof_pos_t             pos0;

  logic                 s1_v_r;
  gof_pos_t             s1_pos_r;
  logic [AW-1:0]        s1_addr_r;
  logic [1:0]           s1_slot_r;
  logic [GOF_PIX_W-1:0] s1_pixel_r;
  logic                 s1_go;
  logic                 emit_ready;
  logic                 job_load;
  gof_col_t             cur_col;
  gof_col_t             p1_r, p2_r;
  gof_job_t             job;

  // Effective frame size
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = 11'd1;
    end else if (frame_height_r > GOF_MAX_HEIGHT) begin
      eff_h = GOF_MAX_HEIGHT;
    end else begin
      eff_h = frame_height_r;
    end
  end

  // Position of the incoming pixel and the results it completes
  always_comb begin
    restart   = (WW'(col_r) >= eff_w) || ({1'b0, row_r} >= eff_h);
    c0        = restart ? '0 : col_r;
    r0        = restart ? '0 : row_r;
    slot0     = restart ? 2'd0 : slot_r;
    row_end0  = ((WW'(c0) + WW'(1)) == eff_w);
    last_row0 = (({1'b0, r0} + 11'd1) == eff_h);

    pos0.mask[RES_UP_PREV] = (r0 != '0) && (c0 != '0);
    pos0.mask[RES_UP_END]  = (r0 != '0) && row_end0;
    pos0.mask[RES_LO_PREV] = last_row0 && (c0 != '0);
    pos0.mask[RES_LO_END]  = last_row0 && row_end0;
    pos0.row         = r0;
    pos0.col_prev    = GOF_COL_OUT_W'(c0 - AW'(1));
    pos0.col_end     = GOF_COL_OUT_W'(eff_w - WW'(1));
    pos0.up_clamp    = (r0 == 10'd1);
    pos0.lo_clamp    = (r0 == '0);
    pos0.lclamp_prev = (c0 == AW'(1));
    pos0.lclamp_end  = (c0 == '0);

    if (row_end0) begin
      col_nxt  = '0;
      row_nxt  = last_row0 ? '0 : r0 + 10'd1;
      slot_nxt = (last_row0 || (slot0 == 2'd2)) ? 2'd0 : slot0 + 2'd1;
    end else begin
      col_nxt  = c0 + AW'(1);
      row_nxt  = r0;
      slot_nxt = slot0;
    end
  end

  // Handshake: the merge stage moves on when its results have a place
  assign s1_go     = s1_v_r && ((s1_pos_r.mask == '0) || emit_ready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_accept = in_tvalid && in_tready;
  assign job_load  = s1_go && (s1_pos_r.mask != '0);

  // Configuration and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= GOF_FW_RESET;
      frame_height_r <= GOF_FH_RESET;
      col_r          <= '0;
      row_r          <= '0;
      slot_r         <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          frame_width_r <= cfg_wdata[GOF_FW_W-1:0];
          col_r         <= '0;
          row_r         <= '0;
          slot_r        <= 2'd0;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_wdata;
          col_r          <= '0;
          row_r          <= '0;
          slot_r         <= 2'd0;
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Merge stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  // Merge stage payload and column window
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos_r   <= pos0;
      s1_addr_r  <= c0;
      s1_slot_r  <= slot0;
      s1_pixel_r <= in_tdata;
    end
    if (s1_go) begin
      p2_r <= p1_r;
      p1_r <= cur_col;
    end
  end

  gof_column_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_addr  (c0),
    .wr_en    (s1_go),
    .wr_addr  (s1_addr_r),
    .wr_slot  (s1_slot_r),
    .wr_pixel (s1_pixel_r),
    .col_out  (cur_col)
  );

  always_comb begin
    job.pos = s1_pos_r;
    job.v2  = p2_r;
    job.v1  = p1_r;
    job.v0  = cur_col;
  end

  gof_emitter u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_load   (job_load),
    .job_in     (job),
    .emit_ready (emit_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // After a pixel is taken the column counter stays inside the row
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (WW'(col_r) < $past(eff_w)))
    else $error("column counter left the row");

endmodule

`default_nettype wire
